>>> hw/rtl/hpf_pkg.sv
// ============================================================================
// hpf_pkg
// Shared types and constants of the heatmap peak finder.
// ============================================================================
package hpf_pkg;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_PART_COUNT     = 2'd2,
        REG_PEAK_THRESHOLD = 2'd3
    } cfg_index_t;

    localparam int                 RES_DEPTH   = 4;
    localparam int                 RES_PW      = $clog2(RES_DEPTH);
    localparam int                 WIDTH_RST   = 1024;
    localparam int                 HEIGHT_RST  = 1024;
    localparam int                 PARTS_RST   = 18;
    localparam logic signed [15:0] THRESH_RST  = 16'sd410;
    localparam logic [15:0]        ID_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [9:0]         x;
        logic [9:0]         y;
        logic [4:0]         part;
        logic signed [15:0] score;
        logic [15:0]        id;
    } result_t;

endpackage

>>> hw/rtl/heatmap_peak_finder.sv
// ============================================================================
// heatmap_peak_finder
// Local maximum peak detector for streamed multi-channel heatmaps.
// ============================================================================
// usage:
//   s_ channel takes one signed q3.12 heat sample per word in raster order,
//   row after row, channel after channel, frame after frame.
//   m_ channel gives one word per peak: x, y, part, score and running id.
//   cfg channel writes frame_width, frame_height, part_count, peak_threshold;
//   write only while the block is idle.
// throughput: one sample per cycle while s_ready is high; the two line stores
//   are single synchronous memories, read at accept, written back in the next
//   cycle, with a forwarding register for the entry written in the same cycle.
// detection: a peak is found when the sample below it arrives; that sample is
//   registered into stage 1 for the compare, then its word enters the queue.
// reset: positions, peak id and result queue clear, registers take their
//   defaults; line stores are not cleared and need no clearing pass.
// stall: a four-word result queue absorbs receiver stalls; s_ready drops
//   only when the queue plus the word in flight could overflow.
// ============================================================================
module heatmap_peak_finder #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_PARTS  = 32
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_heat_value,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [9:0]         m_peak_x,
    output logic [9:0]         m_peak_y,
    output logic [4:0]         m_part_index,
    output logic signed [15:0] m_peak_score,
    output logic [15:0]        m_peak_id
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT);
    localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

    localparam logic [AW:0] W_RST = (AW+1)'((MAX_WIDTH < hpf_pkg::WIDTH_RST) ?
                                            MAX_WIDTH : hpf_pkg::WIDTH_RST);
    localparam logic [HW:0] H_RST = (HW+1)'((MAX_HEIGHT < hpf_pkg::HEIGHT_RST) ?
                                            MAX_HEIGHT : hpf_pkg::HEIGHT_RST);
    localparam logic [PW:0] P_RST = (PW+1)'((MAX_PARTS < hpf_pkg::PARTS_RST) ?
                                            MAX_PARTS : hpf_pkg::PARTS_RST);

    // configuration, held already clamped
    logic [AW:0]        w_eff_reg;
    logic [HW:0]        h_eff_reg;
    logic [PW:0]        p_eff_reg;
    logic signed [15:0] thr_reg;
    logic [AW:0]        w_clamp;
    logic [HW:0]        h_clamp;
    logic [PW:0]        p_clamp;
    logic [10:0]        cfg_w_raw;
    logic [10:0]        cfg_h_raw;
    logic [5:0]         cfg_p_raw;

    // positions
    logic [AW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;
    logic [PW-1:0] ch_reg, ch_next;
    logic [15:0]   cnt_reg, cnt_next;

    // stage 0 decode
    logic          in_fire;
    logic [AW:0]   cx, nx;
    logic [HW:0]   ry, ny;
    logic [PW:0]   cc, nc;
    logic          clr_pre, clr_post;
    logic [AW-1:0] x0, x0_right;
    logic          inner0;

    // stage 1
    logic               s1_valid_reg;
    logic [AW-1:0]      s1_x_reg;
    logic [HW-1:0]      s1_y_reg;
    logic [PW-1:0]      s1_ch_reg;
    logic signed [15:0] s1_cur_reg;
    logic               s1_inner_reg;
    logic signed [15:0] up_rd_reg, ctr_rd_reg, rgt_rd_reg;
    logic signed [15:0] left_reg;
    logic               fw_valid_reg;
    logic [AW-1:0]      fw_addr_reg;
    logic signed [15:0] fw_older_reg, fw_newer_reg;
    logic signed [15:0] up, center, right;
    logic [AW-1:0]      s1_x_right;
    logic               peak;

    // line stores
    logic [15:0] older_mem [MAX_WIDTH];
    logic [15:0] newer_mem [MAX_WIDTH];

    // result queue
    hpf_pkg::result_t                res_mem [hpf_pkg::RES_DEPTH];
    hpf_pkg::result_t                res_in;
    logic [hpf_pkg::RES_PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [hpf_pkg::RES_PW:0]        count_reg, count_next;
    logic                            push, pop;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_w_raw = cfg_data[10:0];
    assign cfg_h_raw = cfg_data[10:0];
    assign cfg_p_raw = cfg_data[5:0];

    always_comb begin
        if (cfg_w_raw == 11'd0) begin
            w_clamp = (AW+1)'(1);
        end else if (int'(cfg_w_raw) > MAX_WIDTH) begin
            w_clamp = (AW+1)'(MAX_WIDTH);
        end else begin
            w_clamp = (AW+1)'(cfg_w_raw);
        end
        if (cfg_h_raw == 11'd0) begin
            h_clamp = (HW+1)'(1);
        end else if (int'(cfg_h_raw) > MAX_HEIGHT) begin
            h_clamp = (HW+1)'(MAX_HEIGHT);
        end else begin
            h_clamp = (HW+1)'(cfg_h_raw);
        end
        if (cfg_p_raw == 6'd0) begin
            p_clamp = (PW+1)'(1);
        end else if (int'(cfg_p_raw) > MAX_PARTS) begin
            p_clamp = (PW+1)'(MAX_PARTS);
        end else begin
            p_clamp = (PW+1)'(cfg_p_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_eff_reg <= W_RST;
            h_eff_reg <= H_RST;
            p_eff_reg <= P_RST;
            thr_reg   <= hpf_pkg::THRESH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                hpf_pkg::REG_FRAME_WIDTH:    w_eff_reg <= w_clamp;
                hpf_pkg::REG_FRAME_HEIGHT:   h_eff_reg <= h_clamp;
                hpf_pkg::REG_PART_COUNT:     p_eff_reg <= p_clamp;
                hpf_pkg::REG_PEAK_THRESHOLD: thr_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 0: position wrap and line store read
    // ------------------------------------------------------------------
    assign s_ready = ({1'b0, count_reg} +
                      {{(hpf_pkg::RES_PW+1){1'b0}}, s1_valid_reg}) <
                     (hpf_pkg::RES_PW+2)'(hpf_pkg::RES_DEPTH);
    assign in_fire = s_valid && s_ready;

    always_comb begin
        cx      = {1'b0, col_reg};
        ry      = {1'b0, row_reg};
        cc      = {1'b0, ch_reg};
        clr_pre = 1'b0;
        if (cx >= w_eff_reg) begin
            cx = '0;
            ry = ry + 1'b1;
        end
        if (ry >= h_eff_reg) begin
            ry = '0;
            cc = cc + 1'b1;
        end
        if (cc >= p_eff_reg) begin
            cc      = '0;
            clr_pre = 1'b1;
        end

        x0       = cx[AW-1:0];
        x0_right = AW'(cx + 1'b1);
        inner0   = (ry >= (HW+1)'(2)) && (cx >= (AW+1)'(1)) &&
                   ((cx + 1'b1) < w_eff_reg);

        nx       = cx + 1'b1;
        ny       = ry;
        nc       = cc;
        clr_post = 1'b0;
        if (nx >= w_eff_reg) begin
            nx = '0;
            ny = ny + 1'b1;
        end
        if (ny >= h_eff_reg) begin
            ny = '0;
            nc = nc + 1'b1;
        end
        if (nc >= p_eff_reg) begin
            nc       = '0;
            clr_post = 1'b1;
        end

        col_next = col_reg;
        row_next = row_reg;
        ch_next  = ch_reg;
        if (in_fire) begin
            col_next = nx[AW-1:0];
            row_next = ny[HW-1:0];
            ch_next  = nc[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            ch_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            ch_reg  <= ch_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            older_mem[s1_x_reg] <= center;
        end
        if (in_fire) begin
            up_rd_reg <= older_mem[x0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            newer_mem[s1_x_reg] <= s1_cur_reg;
        end
        if (in_fire) begin
            ctr_rd_reg <= newer_mem[x0];
            rgt_rd_reg <= newer_mem[x0_right];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_fire;
            fw_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_x_reg     <= x0;
            s1_y_reg     <= ry[HW-1:0];
            s1_ch_reg    <= cc[PW-1:0];
            s1_cur_reg   <= s_heat_value;
            s1_inner_reg <= inner0;
        end
        if (s1_valid_reg) begin
            left_reg     <= center;
        end
        fw_addr_reg  <= s1_x_reg;
        fw_older_reg <= center;
        fw_newer_reg <= s1_cur_reg;
    end

    // ------------------------------------------------------------------
    // stage 1: forwarding, compare, write back
    // ------------------------------------------------------------------
    assign s1_x_right = AW'({1'b0, s1_x_reg} + 1'b1);

    always_comb begin
        up     = up_rd_reg;
        center = ctr_rd_reg;
        right  = rgt_rd_reg;
        if (fw_valid_reg && (fw_addr_reg == s1_x_reg)) begin
            up     = fw_older_reg;
            center = fw_newer_reg;
        end
        if (fw_valid_reg && (fw_addr_reg == s1_x_right)) begin
            right = fw_newer_reg;
        end
        peak = s1_valid_reg && s1_inner_reg && (center > thr_reg) &&
               (center >= up) && (center >= s1_cur_reg) &&
               (center >= left_reg) && (center >= right);
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (in_fire && (clr_pre || clr_post)) begin
            cnt_next = '0;
        end else if (peak && (cnt_reg != hpf_pkg::ID_MAX)) begin
            cnt_next = cnt_reg + 16'd1;
        end
    end

    always_comb begin
        res_in.x     = 10'(s1_x_reg);
        res_in.y     = 10'(s1_y_reg - 1'b1);
        res_in.part  = 5'(s1_ch_reg);
        res_in.score = center;
        res_in.id    = cnt_reg;
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    assign push    = peak;
    assign m_valid = (count_reg != '0);
    assign pop     = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_mem[wr_ptr_reg] <= res_in;
        end
    end

    assign m_peak_x     = res_mem[rd_ptr_reg].x;
    assign m_peak_y     = res_mem[rd_ptr_reg].y;
    assign m_part_index = res_mem[rd_ptr_reg].part;
    assign m_peak_score = res_mem[rd_ptr_reg].score;
    assign m_peak_id    = res_mem[rd_ptr_reg].id;

endmodule

>>> hw/rtl/hpf_checker.sv
// ============================================================================
// hpf_checker
// Port level checks of the heatmap peak finder, bound to the top level.
// ============================================================================
module hpf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [9:0]         m_peak_x,
    input logic [9:0]         m_peak_y,
    input logic [4:0]         m_part_index,
    input logic signed [15:0] m_peak_score,
    input logic [15:0]        m_peak_id
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_peak_x) && $stable(m_peak_y) &&
            $stable(m_part_index) && $stable(m_peak_score) && $stable(m_peak_id))
        else $error("result word changed while stalled");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an empty queue only fills from an accepted input word passed through stage 1
    a_fill_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid) && $past(aresetn) && $past(aresetn, 2)
            |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a matching input word");

endmodule

bind heatmap_peak_finder hpf_checker u_hpf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_peak_x     (m_peak_x),
    .m_peak_y     (m_peak_y),
    .m_part_index (m_part_index),
    .m_peak_score (m_peak_score),
    .m_peak_id    (m_peak_id)
);
